// ===== rtl/sph2d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sph2d_pkg
// Shared constants for the 2-D scatter point histogram: field widths,
// register indexes, register reset values and default sizes.
// ----------------------------------------------------------------------------
package sph2d_pkg;

    // Default grid and counter sizes
    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_COUNT_BITS  = 32;

    // Field widths
    localparam int COORD_W     = 32;
    localparam int BIN_INDEX_W = 12;
    localparam int BINS_W      = 7;
    localparam int OUT_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 80;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BINS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE  = 3'd5;

    // Register reset values
    localparam logic [BINS_W-1:0]  RST_BINS = 7'd64;
    localparam logic [COORD_W-1:0] RST_ORIGIN = 32'd0;
    localparam logic [COORD_W-1:0] RST_SCALE  = 32'd65536;

    // Input item kinds (tuser)
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/sph2d_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sph2d_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
module sph2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/scatter_point_histogram_2d_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scatter_point_histogram_2d_core
// Bins Q16.16 scatter points into a grid of saturating counts held in one
// RAM, and returns the count of a bin on request.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tuser action, tdata point/index
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata bin_count
//   cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// An add item goes through offset, multiply, bin check, address, RAM read and
// write back before the next item is accepted; a dropped point stops after the
// bin check. A read item goes through address, RAM read and write back.
// After reset a clearing pass writes zero to all MAX_COLUMNS*MAX_ROWS
// entries, one per cycle, before the first item is accepted.
// A read result waits in the output register; a stalled output holds the
// next read item in write back until the register frees.
// ----------------------------------------------------------------------------
module scatter_point_histogram_2d_core #(
    parameter int MAX_COLUMNS = sph2d_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = sph2d_pkg::DEF_MAX_ROWS,
    parameter int COUNT_BITS  = sph2d_pkg::DEF_COUNT_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input items
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [31:0] x_coord, [63:32] y_coord, [75:64] bin_index, [79:76] zero
    input  wire logic [sph2d_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] action
    input  wire logic                                s_axis_tuser,
    // result items
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [31:0] bin_count
    output logic      [sph2d_pkg::OUT_W-1:0]         m_axis_tdata,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sph2d_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sph2d_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CB    = $clog2(MAX_COLUMNS + 1);
    localparam int RB    = $clog2(MAX_ROWS + 1);
    localparam int CBR   = (CB > RB) ? CB : RB;
    localparam int CLW   = (CBR > sph2d_pkg::BINS_W) ? CBR : sph2d_pkg::BINS_W;
    localparam int IW    = 2 * CLW;
    localparam int CW    = sph2d_pkg::COORD_W;

    // State codes
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SUB   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_BIN   = 3'd4;
    localparam logic [2:0] ST_IDX   = 3'd5;
    localparam logic [2:0] ST_RD    = 3'd6;
    localparam logic [2:0] ST_WB    = 3'd7;

    logic [2:0] r_state, n_state;

    // Configuration registers
    logic [sph2d_pkg::BINS_W-1:0] r_bins_x, r_bins_y;
    logic [CW-1:0]                r_x_origin, r_x_scale, r_y_origin, r_y_scale;

    // Item registers
    logic                              r_action;
    logic [CW-1:0]                     r_x, r_y;
    logic [sph2d_pkg::BIN_INDEX_W-1:0] r_idx;

    // Datapath registers
    logic [CW:0]     r_mdx, r_mdy;
    logic [CW-1:0]   r_msx, r_msy;
    logic            r_negx, r_negy;
    logic [2*CW-1:0] r_pxl, r_pyl;
    logic [CLW-1:0]  r_col, r_row;
    logic [AW-1:0]   r_addr;
    logic            r_ok;
    logic [AW-1:0]   r_clr_addr;

    // Output register
    logic                      r_out_valid;
    logic [sph2d_pkg::OUT_W-1:0] r_out_data;

    // RAM port signals
    logic                  ram_wr_en, ram_rd_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [COUNT_BITS-1:0] ram_wr_data, ram_rd_data;

    // Combinational datapath
    logic [CLW-1:0]  bx_cl, by_cl, bx_ext, by_ext;
    logic [CW:0]     dx, dy;
    logic [CW:0]     ipx, ipy;
    logic            okx, oky;
    logic [IW-1:0]   grid, add_idx, rd_idx;
    logic [63:0]     cnt64;
    logic [sph2d_pkg::OUT_W-1:0] rd_result;
    logic            out_free, cnt_full;

    // Clamp the grid size to the store dimensions
    always_comb begin
        bx_ext = CLW'(r_bins_x);
        by_ext = CLW'(r_bins_y);
        bx_cl  = (bx_ext > CLW'(MAX_COLUMNS)) ? CLW'(MAX_COLUMNS) : bx_ext;
        by_cl  = (by_ext > CLW'(MAX_ROWS)) ? CLW'(MAX_ROWS) : by_ext;
    end

    // Offset the coordinates
    assign dx = {r_x[CW-1], r_x} - {r_x_origin[CW-1], r_x_origin};
    assign dy = {r_y[CW-1], r_y} - {r_y_origin[CW-1], r_y_origin};

    // Integer part of |d|*|scale|: low product plus the top bit of |d|
    assign ipx = {1'b0, r_pxl[2*CW-1:CW]} + (r_mdx[CW] ? {1'b0, r_msx} : '0);
    assign ipy = {1'b0, r_pyl[2*CW-1:CW]} + (r_mdy[CW] ? {1'b0, r_msy} : '0);
    assign okx = !(r_negx && (ipx != '0)) && (ipx < (CW+1)'(bx_cl));
    assign oky = !(r_negy && (ipy != '0)) && (ipy < (CW+1)'(by_cl));

    // Bin addresses
    assign grid    = IW'(bx_cl) * IW'(by_cl);
    assign add_idx = IW'(r_col) * IW'(by_cl) + IW'(r_row);
    assign rd_idx  = IW'(r_idx);

    // Read result, saturated to the output width
    assign cnt64     = 64'(ram_rd_data);
    assign rd_result = !r_ok ? '0 :
                       (|cnt64[63:32]) ? {sph2d_pkg::OUT_W{1'b1}} : cnt64[31:0];
    assign cnt_full  = (ram_rd_data == {COUNT_BITS{1'b1}});
    assign out_free  = !r_out_valid || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (s_axis_tuser == sph2d_pkg::ACT_READ) ? ST_IDX : ST_SUB;
                end
            end
            ST_SUB:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_BIN;
            ST_BIN:  n_state = (okx && oky) ? ST_IDX : ST_IDLE;
            ST_IDX:  n_state = ST_RD;
            ST_RD:   n_state = ST_WB;
            ST_WB: begin
                if (r_action == sph2d_pkg::ACT_ADD || out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // RAM access: clearing pass, read, write back
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_addr;
        ram_wr_data = ram_rd_data + COUNT_BITS'(1);
        ram_rd_en   = (r_state == ST_RD);
        if (r_state == ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = '0;
        end else if (r_state == ST_WB && r_action == sph2d_pkg::ACT_ADD) begin
            ram_wr_en = r_ok && !cnt_full;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            if (r_state == ST_WB && r_action == sph2d_pkg::ACT_READ && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins_x   <= sph2d_pkg::RST_BINS;
            r_bins_y   <= sph2d_pkg::RST_BINS;
            r_x_origin <= sph2d_pkg::RST_ORIGIN;
            r_x_scale  <= sph2d_pkg::RST_SCALE;
            r_y_origin <= sph2d_pkg::RST_ORIGIN;
            r_y_scale  <= sph2d_pkg::RST_SCALE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sph2d_pkg::REG_BINS_X:   r_bins_x   <= i_cfg_data[sph2d_pkg::BINS_W-1:0];
                sph2d_pkg::REG_BINS_Y:   r_bins_y   <= i_cfg_data[sph2d_pkg::BINS_W-1:0];
                sph2d_pkg::REG_X_ORIGIN: r_x_origin <= i_cfg_data;
                sph2d_pkg::REG_X_SCALE:  r_x_scale  <= i_cfg_data;
                sph2d_pkg::REG_Y_ORIGIN: r_y_origin <= i_cfg_data;
                sph2d_pkg::REG_Y_SCALE:  r_y_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // capture the accepted item
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_action <= s_axis_tuser;
            r_x      <= s_axis_tdata[CW-1:0];
            r_y      <= s_axis_tdata[2*CW-1:CW];
            r_idx    <= s_axis_tdata[2*CW+sph2d_pkg::BIN_INDEX_W-1:2*CW];
        end
        // take magnitudes and product sign
        if (r_state == ST_SUB) begin
            r_negx <= dx[CW] ^ r_x_scale[CW-1];
            r_negy <= dy[CW] ^ r_y_scale[CW-1];
            r_mdx  <= dx[CW] ? -dx : dx;
            r_mdy  <= dy[CW] ? -dy : dy;
            r_msx  <= r_x_scale[CW-1] ? -r_x_scale : r_x_scale;
            r_msy  <= r_y_scale[CW-1] ? -r_y_scale : r_y_scale;
        end
        // multiply the low 32 bits of the magnitudes
        if (r_state == ST_MUL) begin
            r_pxl <= (2*CW)'(r_mdx[CW-1:0]) * (2*CW)'(r_msx);
            r_pyl <= (2*CW)'(r_mdy[CW-1:0]) * (2*CW)'(r_msy);
        end
        // hold column and row
        if (r_state == ST_BIN) begin
            r_col <= ipx[CLW-1:0];
            r_row <= ipy[CLW-1:0];
        end
        // form the store address and, for a read, the range check
        if (r_state == ST_IDX) begin
            if (r_action == sph2d_pkg::ACT_READ) begin
                r_addr <= rd_idx[AW-1:0];
                r_ok   <= (rd_idx < grid);
            end else begin
                r_addr <= add_idx[AW-1:0];
                r_ok   <= 1'b1;
            end
        end
        // load the read result
        if (r_state == ST_WB && r_action == sph2d_pkg::ACT_READ && out_free) begin
            r_out_data <= rd_result;
        end
    end

    // Count store
    sph2d_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (ram_rd_data)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

endmodule
`default_nettype wire
